@@ rtl/iirl_pkg.sv @@
// ----------------------------------------------------------------------------
// Indexed insert/remove list package
// Operation codes, cell commands and controller states of the list core; the
// cell commands are shared with its storage cells.
// ----------------------------------------------------------------------------
`default_nettype none

package iirl_pkg;

  localparam int POS_W = 7;
  localparam int OUT_W = 32;
  localparam int CNT_W = 7;

  typedef enum logic [2:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_REMOVE = 3'd2,
    OP_PUT    = 3'd3,
    OP_GET    = 3'd4
  } op_code_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_PUT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     rd_load;
  } cell_cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_t;

endpackage

`default_nettype wire

@@ rtl/iirl_cell.sv @@
// ----------------------------------------------------------------------------
// Indexed insert/remove list cell
// Holds one list entry and one stage of the read chain. Entries move to the
// upper neighbor on insert and to the lower neighbor on remove.
// ----------------------------------------------------------------------------
`default_nettype none

module iirl_cell #(
  parameter int IDX = 0,
  parameter int PW  = 7,
  parameter int DW  = 32
) (
  input  wire logic               clk,
  input  wire iirl_pkg::cell_cmd_t cmd,
  input  wire logic [PW-1:0]      cmd_pos,
  input  wire logic [DW-1:0]      cmd_value,
  input  wire logic [DW-1:0]      left_entry,
  input  wire logic [DW-1:0]      right_entry,
  input  wire logic [DW-1:0]      rc_in,
  output logic      [DW-1:0]      entry,
  output logic      [DW-1:0]      rc_out
);
  import iirl_pkg::*;

  localparam logic [31:0] IDX_V = 32'(IDX);

  logic [DW-1:0] entry_r, entry_nxt;
  logic [DW-1:0] rc_r, rc_nxt;
  logic [31:0]   pos_v;
  logic          hit;
  logic          above;

  assign pos_v = 32'(cmd_pos);
  assign hit   = (IDX_V == pos_v);
  assign above = (IDX_V > pos_v);

  always_comb begin
    entry_nxt = entry_r;
    case (cmd.op)
      CELL_INSERT: begin
        if (above) begin
          entry_nxt = left_entry;
        end else if (hit) begin
          entry_nxt = cmd_value;
        end
      end
      CELL_REMOVE: begin
        if (above || hit) begin
          entry_nxt = right_entry;
        end
      end
      CELL_PUT: begin
        if (hit) begin
          entry_nxt = cmd_value;
        end
      end
      default: entry_nxt = entry_r;
    endcase
  end

  assign rc_nxt = (cmd.rd_load && hit) ? entry_r : rc_in;

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    rc_r    <= rc_nxt;
  end

  assign entry  = entry_r;
  assign rc_out = rc_r;

endmodule

`default_nettype wire

@@ rtl/indexed_insert_remove_list_core.sv @@
// ----------------------------------------------------------------------------
// Indexed insert/remove list core
// Append, insert, put and rejected transactions need no walk; the result is
// registered at accept. An accepted get or remove loads the entry at its position
// into the cell read chain, which carries it down to cell 0, one cell per cycle.
// Up to one transaction is accepted per cycle; a get or remove holds the input
// for its whole walk. Reset clears the fill count and handshake state only.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_insert_remove_list_core #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [2:0]                  in_op,
  input  wire logic [iirl_pkg::POS_W-1:0]  in_position,
  input  wire logic [31:0]                 in_value,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic      [iirl_pkg::OUT_W-1:0]  out_read_value,
  output logic                             out_ok,
  output logic      [iirl_pkg::CNT_W-1:0]  out_count
);
  import iirl_pkg::*;

  localparam int IW = $clog2(CAPACITY + 1);
  localparam int PW = (IW > POS_W) ? IW : POS_W;
  localparam int DW = DATA_WIDTH;

  state_t          state_r, state_nxt;
  logic [IW-1:0]   fill_r, fill_nxt;
  logic [POS_W-1:0] walk_cnt_r, walk_cnt_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] read_value_r, read_value_nxt;
  logic            ok_r, ok_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  logic            accept;
  logic            walk_done;
  logic            ok;
  logic            rd_op;
  logic            grow;
  logic            shrink;
  cell_op_t        cop;
  logic [PW-1:0]   cpos;
  logic [PW-1:0]   pos_e;
  logic [PW-1:0]   fill_e;
  logic            full;
  logic            in_range;
  cell_cmd_t       cmd;
  logic [63:0]     val_ext;
  logic [DW-1:0]   word;
  logic [63:0]     rd_ext;
  logic [63:0]     cnt_ext;

  logic [DW-1:0]   entry_w [CAPACITY];
  logic [DW-1:0]   rc_w    [CAPACITY];

  assign pos_e    = PW'(in_position);
  assign fill_e   = PW'(fill_r);
  assign full     = (fill_r == IW'(CAPACITY));
  assign in_range = (pos_e < fill_e);
  assign val_ext  = 64'(in_value);
  assign word     = val_ext[DW-1:0];

  always_comb begin
    ok     = 1'b0;
    rd_op  = 1'b0;
    cop    = CELL_HOLD;
    cpos   = pos_e;
    grow   = 1'b0;
    shrink = 1'b0;
    unique case (op_code_t'(in_op))
      OP_APPEND: begin
        ok   = !full;
        cop  = CELL_INSERT;
        cpos = fill_e;
        grow = 1'b1;
      end
      OP_INSERT: begin
        ok   = !full && (pos_e <= fill_e);
        cop  = CELL_INSERT;
        grow = 1'b1;
      end
      OP_REMOVE: begin
        ok     = in_range;
        cop    = CELL_REMOVE;
        rd_op  = 1'b1;
        shrink = 1'b1;
      end
      OP_PUT: begin
        ok  = in_range;
        cop = CELL_PUT;
      end
      OP_GET: begin
        ok    = in_range;
        rd_op = 1'b1;
      end
      default: ok = 1'b0;
    endcase
  end

  assign cmd.op      = (accept && ok) ? cop : CELL_HOLD;
  assign cmd.rd_load = accept && ok && rd_op;

  always_comb begin
    fill_nxt = fill_r;
    if (accept && ok && grow) begin
      fill_nxt = fill_r + IW'(1);
    end else if (accept && ok && shrink) begin
      fill_nxt = fill_r - IW'(1);
    end
  end

  assign cnt_ext = 64'(fill_nxt);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && ok && rd_op) begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (walk_cnt_r == '0) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    walk_done = 1'b0;
    unique case (state_r)
      ST_IDLE: in_ready  = !out_valid_r || out_ready;
      ST_WALK: walk_done = (walk_cnt_r == '0);
      default: in_ready  = 1'b0;
    endcase
  end

  assign accept = in_valid && in_ready;
  assign rd_ext = 64'(rc_w[0]);

  always_comb begin
    walk_cnt_nxt   = walk_cnt_r;
    out_valid_nxt  = out_valid_r;
    read_value_nxt = read_value_r;
    ok_nxt         = ok_r;
    count_nxt      = count_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (accept) begin
      ok_nxt         = ok;
      count_nxt      = cnt_ext[CNT_W-1:0];
      read_value_nxt = '0;
      walk_cnt_nxt   = in_position;
      if (!(ok && rd_op)) begin
        out_valid_nxt = 1'b1;
      end
    end else if (state_r == ST_WALK) begin
      if (walk_done) begin
        read_value_nxt = rd_ext[OUT_W-1:0];
        out_valid_nxt  = 1'b1;
      end else begin
        walk_cnt_nxt = walk_cnt_r - POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      walk_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      walk_cnt_r  <= walk_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    read_value_r <= read_value_nxt;
    ok_r         <= ok_nxt;
    count_r      <= count_nxt;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DW-1:0] left_in;
    logic [DW-1:0] right_in;
    logic [DW-1:0] rc_in;

    if (i == 0) begin : g_first
      assign left_in = word;
    end else begin : g_mid_left
      assign left_in = entry_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_in = entry_w[i];
      assign rc_in    = '0;
    end else begin : g_mid_right
      assign right_in = entry_w[i+1];
      assign rc_in    = rc_w[i+1];
    end

    iirl_cell #(
      .IDX (i),
      .PW  (PW),
      .DW  (DW)
    ) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .cmd_pos     (cpos),
      .cmd_value   (word),
      .left_entry  (left_in),
      .right_entry (right_in),
      .rc_in       (rc_in),
      .entry       (entry_w[i]),
      .rc_out      (rc_w[i])
    );
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = read_value_r;
  assign out_ok         = ok_r;
  assign out_count      = count_r;

endmodule

`default_nettype wire

@@ dv/indexed_insert_remove_list_core_test.sv @@
// ----------------------------------------------------------------------------
// Indexed insert/remove list core testbench
// Drives append, insert, remove, put and get transactions, including rejected
// and unused operations, into the list core under random idling on both sides.
// A shadow list predicts every result, and each result is compared field by
// field with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_insert_remove_list_core_test;
  import iirl_pkg::*;

  localparam int LIST_DEPTH = 64;
  localparam int WORD_W = 32;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES = 240;
  localparam logic [2:0] OP_RESERVED_FIRST = 3'd5;
  localparam logic [2:0] OP_RESERVED_MID = 3'd6;
  localparam logic [2:0] OP_RESERVED_LAST = 3'd7;

  typedef struct packed {
    logic [OUT_W-1:0] read_value;
    logic             ok;
    logic [CNT_W-1:0] count;
  } list_result_t;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [2:0]         in_op = '0;
  logic [POS_W-1:0]   in_position = '0;
  logic [31:0]        in_value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [OUT_W-1:0]   out_read_value;
  logic               out_ok;
  logic [CNT_W-1:0]   out_count;

  logic [WORD_W-1:0]  shadow_words [LIST_DEPTH];
  int unsigned        shadow_fill = 0;
  int unsigned        peak_fill = 0;
  list_result_t       pending_results [$];

  int                 in_idle_pct = 36;
  int                 out_idle_pct = 36;
  int                 hold_request = 0;
  int                 hold_seen = 0;
  int                 hold_left = 0;
  int                 stall_cycles = 0;
  int                 error_count = 0;
  int                 sent_count = 0;
  int                 done_count = 0;
  int                 rejected_count = 0;

  indexed_insert_remove_list_core #(
    .CAPACITY  (LIST_DEPTH),
    .DATA_WIDTH(WORD_W)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_op         (in_op),
    .in_position   (in_position),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_read_value(out_read_value),
    .out_ok        (out_ok),
    .out_count     (out_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic list_result_t predict_list_op(input logic [2:0] op,
                                                   input logic [POS_W-1:0] pos,
                                                   input logic [31:0] val);
    list_result_t res;
    int unsigned  idx;
    int unsigned  i;
    res = '0;
    case (op)
      OP_APPEND, OP_INSERT: begin
        idx = (op == OP_APPEND) ? shadow_fill : int'(pos);
        if (idx <= shadow_fill && shadow_fill < LIST_DEPTH) begin
          for (i = shadow_fill; i > idx; i--) shadow_words[i] = shadow_words[i - 1];
          shadow_words[idx] = val;
          shadow_fill++;
          res.ok = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (pos < shadow_fill) begin
          res.read_value = shadow_words[pos];
          for (i = pos; i + 1 < shadow_fill; i++) shadow_words[i] = shadow_words[i + 1];
          shadow_fill--;
          res.ok = 1'b1;
        end
      end
      OP_PUT: begin
        if (pos < shadow_fill) begin
          shadow_words[pos] = val;
          res.ok = 1'b1;
        end
      end
      OP_GET: begin
        if (pos < shadow_fill) begin
          res.read_value = shadow_words[pos];
          res.ok = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (shadow_fill > peak_fill) peak_fill = shadow_fill;
    res.count = CNT_W'(shadow_fill);
    return res;
  endfunction

  task automatic send_list_op(input logic [2:0] op, input logic [POS_W-1:0] pos,
                              input logic [31:0] val);
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    in_valid    <= 1'b1;
    in_op       <= op;
    in_position <= pos;
    in_value    <= val;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_list_op(op, pos, val));
    sent_count++;
  endtask

  task automatic send_random_op(input int grow_pct);
    int unsigned      roll;
    logic [2:0]       op;
    logic [POS_W-1:0] pos;
    roll = $urandom_range(99);
    if (roll < 4) begin
      op = 3'($urandom_range(OP_RESERVED_LAST, OP_RESERVED_FIRST));
    end else if (roll < grow_pct) begin
      op = $urandom_range(1) ? OP_APPEND : OP_INSERT;
    end else begin
      case ($urandom_range(2))
        0: op = OP_REMOVE;
        1: op = OP_PUT;
        default: op = OP_GET;
      endcase
    end
    roll = $urandom_range(99);
    if (roll < 8) pos = POS_W'($urandom_range(127));
    else if (roll < 16 || shadow_fill == 0) pos = POS_W'(shadow_fill);
    else pos = POS_W'($urandom_range(shadow_fill - 1));
    send_list_op(op, pos, $urandom);
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("ERROR: result %0d field %s is %0h, predicted %0h", done_count, field, got, want);
    error_count++;
  endtask

  task automatic check_result();
    list_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("valid", 32'd1, 32'd0);
    end else begin
      want = pending_results.pop_front();
      if (out_read_value !== want.read_value)
        report_mismatch("read_value", out_read_value, want.read_value);
      if (out_ok !== want.ok) report_mismatch("ok", 32'(out_ok), 32'(want.ok));
      if (out_count !== want.count) report_mismatch("count", 32'(out_count), 32'(want.count));
      if (want.ok) done_count++;
      else rejected_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_result();
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_request != hold_seen) begin
      hold_seen <= hold_request;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && !((in_valid && in_ready) || (out_valid && out_ready))) begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end else begin
      stall_cycles <= 0;
    end
  end

  task automatic test_empty_list();
    send_list_op(OP_GET, 7'd0, 32'h0000_0001);
    send_list_op(OP_REMOVE, 7'd0, 32'h0);
    send_list_op(OP_PUT, 7'd0, 32'hDEAD_BEEF);
    send_list_op(OP_INSERT, 7'd1, 32'h1111_1111);
    send_list_op(OP_RESERVED_FIRST, 7'd0, 32'h0);
    send_list_op(OP_RESERVED_LAST, 7'd127, 32'hFFFF_FFFF);
  endtask

  task automatic test_edge_operations();
    int i;
    send_list_op(OP_APPEND, 7'd0, 32'h0000_0000);
    send_list_op(OP_APPEND, 7'd127, 32'hFFFF_FFFF);
    send_list_op(OP_INSERT, 7'd0, 32'hA5A5_A5A5);
    send_list_op(OP_INSERT, 7'd3, 32'h5A5A_5A5A);
    send_list_op(OP_INSERT, 7'd2, 32'h1234_5678);
    send_list_op(OP_INSERT, 7'd6, 32'h8765_4321);
    for (i = 0; i < 5; i++) send_list_op(OP_GET, POS_W'(i), 32'h0);
    send_list_op(OP_PUT, 7'd4, 32'h0F0F_0F0F);
    send_list_op(OP_PUT, 7'd5, 32'hF0F0_F0F0);
    send_list_op(OP_GET, 7'd4, 32'h0);
    send_list_op(OP_REMOVE, 7'd4, 32'h0);
    send_list_op(OP_REMOVE, 7'd0, 32'h0);
    send_list_op(OP_GET, 7'd64, 32'h0);
    send_list_op(OP_REMOVE, 7'd127, 32'h0);
    send_list_op(OP_RESERVED_MID, 7'd1, 32'h0);
  endtask

  task automatic test_fill_and_drain();
    while (shadow_fill < LIST_DEPTH) begin
      if ($urandom_range(1)) send_list_op(OP_APPEND, POS_W'($urandom_range(127)), $urandom);
      else send_list_op(OP_INSERT, POS_W'($urandom_range(shadow_fill)), $urandom);
    end
    send_list_op(OP_APPEND, 7'd0, $urandom);
    send_list_op(OP_INSERT, 7'd0, $urandom);
    send_list_op(OP_INSERT, 7'd64, $urandom);
    send_list_op(OP_GET, 7'd63, 32'h0);
    send_list_op(OP_PUT, 7'd63, $urandom);
    send_list_op(OP_GET, 7'd63, 32'h0);
    send_list_op(OP_GET, 7'd64, 32'h0);
    while (shadow_fill > 0) begin
      case ($urandom_range(2))
        0: send_list_op(OP_REMOVE, 7'd0, $urandom);
        1: send_list_op(OP_REMOVE, POS_W'(shadow_fill - 1), $urandom);
        default: send_list_op(OP_REMOVE, POS_W'($urandom_range(shadow_fill - 1)), $urandom);
      endcase
    end
  endtask

  task automatic test_random_mix(input int num_items);
    int i;
    for (i = 0; i < num_items; i++) send_random_op(((i / 100) % 2 == 0) ? 70 : 22);
  endtask

  task automatic test_output_hold();
    int i;
    in_idle_pct = 0;
    hold_request <= hold_request + 1;
    for (i = 0; i < 40; i++) send_random_op(60);
    in_idle_pct = 36;
  endtask

  task automatic test_back_to_back(input int num_items);
    int i;
    in_idle_pct = 0;
    out_idle_pct <= 0;
    for (i = 0; i < num_items; i++) send_random_op(((i / 80) % 2 == 0) ? 75 : 20);
    in_idle_pct = 36;
    out_idle_pct <= 36;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_list();
    test_edge_operations();
    test_fill_and_drain();
    test_random_mix(1100);
    test_output_hold();
    test_back_to_back(300);
    test_random_mix(60);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LIST_DEPTH + 8) @(posedge clk);
    $display("Ran %0d transactions: %0d done, %0d rejected, list filled up to %0d of %0d.",
             sent_count, done_count, rejected_count, peak_fill, LIST_DEPTH);
    $display("Covered empty and full list, reserved codes, back-pressure and stalled input.");
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
